[design/obst_pkg.sv]
// Shared types and constants for the optimal BST cost table unit.
`timescale 1ns / 1ps
package obst_pkg;

  localparam int unsigned IDX_W  = 4;
  localparam int unsigned WGT_W  = 12;
  localparam int unsigned SUM_W  = 17;
  localparam int unsigned COST_W = 24;
  localparam int unsigned BEST_W = 30;
  localparam logic [BEST_W-1:0] COST_START = 30'h3000_0000;
  localparam logic [COST_W-1:0] COST_MAX   = 24'hFF_FFFF;

  typedef struct packed {
    logic [WGT_W-1:0] key_weight;
    logic [WGT_W-1:0] gap_weight;
    logic             last_item;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  range_start;
    logic [IDX_W-1:0]  range_end;
    logic [IDX_W-1:0]  best_root;
    logic [COST_W-1:0] range_cost;
    logic              last_result;
    logic              overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_WRD, ST_WWR, ST_KRD, ST_KCMP, ST_EWR, ST_ERD, ST_ELD, ST_OUT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic             load_q0;
    logic             load_key;
    logic             init_wr;
    logic             w_wr;
    logic             k_cmp;
    logic             e_wr;
    logic             out_rd;
    logic             out_ld;
    logic             out_last;
    logic             out_ovf;
    logic [IDX_W-1:0] ld_idx;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
  } cmd_t;

endpackage

[design/obst_ctrl.sv]
// Controller: load counting, DP loop sequencing and result emission.
`timescale 1ns / 1ps
module obst_ctrl #(
  parameter int unsigned MAX_KEYS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output obst_pkg::cmd_t   cmd_o
);

  localparam logic [obst_pkg::IDX_W-1:0] MaxK = obst_pkg::IDX_W'(MAX_KEYS);
  localparam logic [obst_pkg::IDX_W-1:0] One  = obst_pkg::IDX_W'(1);

  obst_pkg::state_e state_q, state_d;
  logic [obst_pkg::IDX_W-1:0] cnt_q, cnt_d, n_q, n_d, i_q, i_d, j_q, j_d, k_q, k_d;
  logic [obst_pkg::IDX_W-1:0] len_q, len_d;
  logic drop_q, drop_d;
  logic in_xfer, out_xfer, is_last;

  assign in_xfer  = in_valid_i && (state_q == obst_pkg::ST_IDLE);
  assign out_xfer = (state_q == obst_pkg::ST_OUT) && !out_stall_i;
  assign is_last  = (i_q == One) && (j_q == n_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      obst_pkg::ST_IDLE: if (in_xfer && in_last_i) state_d = obst_pkg::ST_INIT;
      obst_pkg::ST_INIT: begin
        if (i_q == n_q + One) state_d = (n_q == '0) ? obst_pkg::ST_ERD : obst_pkg::ST_WRD;
      end
      obst_pkg::ST_WRD:  state_d = obst_pkg::ST_WWR;
      obst_pkg::ST_WWR:  state_d = obst_pkg::ST_KRD;
      obst_pkg::ST_KRD:  state_d = obst_pkg::ST_KCMP;
      obst_pkg::ST_KCMP: state_d = (k_q == j_q) ? obst_pkg::ST_EWR : obst_pkg::ST_KRD;
      obst_pkg::ST_EWR: begin
        if (j_q == n_q && len_q == n_q) state_d = obst_pkg::ST_ERD;
        else state_d = obst_pkg::ST_WRD;
      end
      obst_pkg::ST_ERD:  state_d = obst_pkg::ST_ELD;
      obst_pkg::ST_ELD:  state_d = obst_pkg::ST_OUT;
      obst_pkg::ST_OUT: begin
        if (out_xfer) state_d = is_last ? obst_pkg::ST_IDLE : obst_pkg::ST_ERD;
      end
      default: state_d = obst_pkg::ST_IDLE;
    endcase
  end

  // counters
  always_comb begin
    cnt_d  = cnt_q;
    n_d    = n_q;
    i_d    = i_q;
    j_d    = j_q;
    k_d    = k_q;
    len_d  = len_q;
    drop_d = drop_q;
    unique case (state_q)
      obst_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (cnt_q == '0) cnt_d = One;
          else if (cnt_q - One < MaxK) cnt_d = cnt_q + One;
          else drop_d = 1'b1;
          n_d = cnt_d - One;
          i_d = One;
        end
      end
      obst_pkg::ST_INIT: begin
        i_d = i_q + One;
        if (i_q == n_q + One) begin
          if (n_q == '0) begin
            i_d = One;
            j_d = '0;
          end else begin
            i_d   = One;
            j_d   = One;
            len_d = One;
          end
        end
      end
      obst_pkg::ST_WWR:  k_d = i_q;
      obst_pkg::ST_KCMP: k_d = k_q + One;
      obst_pkg::ST_EWR: begin
        if (j_q != n_q) begin
          i_d = i_q + One;
          j_d = j_q + One;
        end else if (len_q == n_q) begin
          i_d = n_q;
          j_d = n_q;
        end else begin
          len_d = len_q + One;
          i_d   = One;
          j_d   = len_q + One;
        end
      end
      obst_pkg::ST_OUT: begin
        if (out_xfer) begin
          if (is_last) begin
            cnt_d  = '0;
            drop_d = 1'b0;
          end else if (j_q != n_q) begin
            j_d = j_q + One;
          end else begin
            i_d = i_q - One;
            j_d = i_q - One;
          end
        end
      end
      default: ;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.ld_idx   = cnt_q;
    cmd_o.i        = i_q;
    cmd_o.j        = j_q;
    cmd_o.k        = k_q;
    cmd_o.out_last = is_last;
    cmd_o.out_ovf  = drop_q;
    cmd_o.load_q0  = in_xfer && (cnt_q == '0);
    cmd_o.load_key = in_xfer && (cnt_q != '0) && (cnt_q - One < MaxK);
    cmd_o.init_wr  = (state_q == obst_pkg::ST_INIT) && (i_q != n_q + One + One);
    cmd_o.w_wr     = (state_q == obst_pkg::ST_WWR);
    cmd_o.k_cmp    = (state_q == obst_pkg::ST_KCMP);
    cmd_o.e_wr     = (state_q == obst_pkg::ST_EWR);
    cmd_o.out_rd   = (state_q == obst_pkg::ST_ERD);
    cmd_o.out_ld   = (state_q == obst_pkg::ST_ELD);
  end

  assign in_stall_o  = (state_q != obst_pkg::ST_IDLE);
  assign out_valid_o = (state_q == obst_pkg::ST_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= obst_pkg::ST_IDLE;
      cnt_q   <= '0;
      n_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      len_q   <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      len_q   <= len_d;
      drop_q  <= drop_d;
    end
  end

endmodule

[design/obst_dp.sv]
// Datapath: weight registers, DP table memories, cost compare and output register.
`timescale 1ns / 1ps
module obst_dp #(
  parameter int unsigned MAX_KEYS = 8
) (
  input  logic                clk_i,
  input  obst_pkg::in_item_t  in_data_i,
  input  obst_pkg::cmd_t      cmd_i,
  output obst_pkg::out_item_t out_data_o
);

  localparam int unsigned TAB   = MAX_KEYS + 2;
  localparam int unsigned DEPTH = TAB * TAB;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned WN    = MAX_KEYS + 1;
  localparam int unsigned WIW   = $clog2(WN);
  localparam logic [obst_pkg::IDX_W-1:0] One = obst_pkg::IDX_W'(1);

  function automatic logic [AW-1:0] addr(input logic [obst_pkg::IDX_W-1:0] r,
                                         input logic [obst_pkg::IDX_W-1:0] c);
    addr = AW'(int'(r) * TAB + int'(c));
  endfunction

  logic [obst_pkg::WGT_W-1:0]  kw_q [WN];
  logic [obst_pkg::WGT_W-1:0]  gp_q [WN];
  logic [obst_pkg::SUM_W-1:0]  w_mem [DEPTH];
  logic [obst_pkg::COST_W-1:0] e_mem [DEPTH];
  logic [obst_pkg::IDX_W-1:0]  r_mem [DEPTH];

  logic [obst_pkg::SUM_W-1:0]  w_rd_q, tot_q, tot;
  logic [obst_pkg::COST_W-1:0] ea_q, eb_q;
  logic [obst_pkg::IDX_W-1:0]  r_rd_q, broot_q, gidx;
  logic [obst_pkg::BEST_W-1:0] best_q;
  logic [obst_pkg::COST_W+1:0] csum;
  logic [obst_pkg::COST_W-1:0] csat;
  logic [AW-1:0] a_rd, b_rd, w_ra, ij, init_a;
  logic [obst_pkg::WGT_W-1:0] gval, kval;
  obst_pkg::out_item_t out_q;

  // load weights
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_q0) gp_q[0] <= in_data_i.gap_weight;
    if (cmd_i.load_key) begin
      kw_q[cmd_i.ld_idx[WIW-1:0]] <= in_data_i.key_weight;
      gp_q[cmd_i.ld_idx[WIW-1:0]] <= in_data_i.gap_weight;
    end
  end

  // gap read at i-1 during init, at j otherwise
  assign gidx = cmd_i.init_wr ? cmd_i.i - One : cmd_i.j;
  assign gval = gp_q[gidx[WIW-1:0]];
  assign kval = kw_q[cmd_i.j[WIW-1:0]];

  assign ij     = addr(cmd_i.i, cmd_i.j);
  assign init_a = addr(cmd_i.i, cmd_i.i - One);
  assign w_ra   = addr(cmd_i.i, cmd_i.j - One);
  assign a_rd   = cmd_i.out_rd || cmd_i.e_wr ? ij : addr(cmd_i.i, cmd_i.k - One);
  assign b_rd   = addr(cmd_i.k + One, cmd_i.j);

  // table memories, registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_wr) begin
      w_mem[init_a] <= obst_pkg::SUM_W'(gval);
      e_mem[init_a] <= obst_pkg::COST_W'(gval);
      r_mem[init_a] <= '0;
    end else begin
      if (cmd_i.w_wr) w_mem[ij] <= tot;
      if (cmd_i.e_wr) begin
        e_mem[ij] <= best_q[obst_pkg::COST_W-1:0];
        r_mem[ij] <= broot_q;
      end
    end
    w_rd_q <= w_mem[w_ra];
    ea_q   <= e_mem[a_rd];
    eb_q   <= e_mem[b_rd];
    r_rd_q <= r_mem[ij];
  end

  assign tot  = w_rd_q + obst_pkg::SUM_W'(kval) + obst_pkg::SUM_W'(gval);
  assign csum = (obst_pkg::COST_W+2)'(ea_q) + (obst_pkg::COST_W+2)'(eb_q)
              + (obst_pkg::COST_W+2)'(tot_q);
  assign csat = (csum > (obst_pkg::COST_W+2)'(obst_pkg::COST_MAX))
              ? obst_pkg::COST_MAX : csum[obst_pkg::COST_W-1:0];

  // running minimum over candidate roots
  always_ff @(posedge clk_i) begin
    if (cmd_i.w_wr) begin
      tot_q   <= tot;
      best_q  <= obst_pkg::COST_START;
      broot_q <= '0;
    end else if (cmd_i.k_cmp && (obst_pkg::BEST_W'(csat) < best_q)) begin
      best_q  <= obst_pkg::BEST_W'(csat);
      broot_q <= cmd_i.k;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_q.range_start <= cmd_i.i;
      out_q.range_end   <= cmd_i.j;
      out_q.best_root   <= r_rd_q;
      out_q.range_cost  <= ea_q;
      out_q.last_result <= cmd_i.out_last;
      out_q.overflow    <= cmd_i.out_ovf;
    end
  end

  assign out_data_o = out_q;

endmodule

[design/optimal_bst_cost_table_unit.sv]
// Top level of the optimal binary search tree cost table unit.
// Loads one problem as a run of items (q0 first, then key/gap pairs, last one
// marked), then solves the optimal BST over weight sums, costs and roots and
// sends one result per subrange (i,j), rows from i=n down to 1, j rising.
// Items are taken while idle. After the marked item the input stalls while the
// solver runs: an init pass over the n+1 empty subranges, then per subrange a
// weight sum write, a read and compare per candidate root in the single-adder
// compare loop and a cost write, then each result goes from the table read
// port to the output register and holds while the output stalls. Items past
// MAX_KEYS keys are dropped and reported in the overflow field.
`timescale 1ns / 1ps
module optimal_bst_cost_table_unit #(
  parameter int unsigned MAX_KEYS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  obst_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output obst_pkg::out_item_t out_data_o
);

  obst_pkg::cmd_t cmd;

  obst_ctrl #(.MAX_KEYS(MAX_KEYS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last_item),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  obst_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
    .clk_i     (clk_i),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .out_data_o(out_data_o)
  );

endmodule

[design/obst_checker.sv]
// Port-level checker for the optimal BST cost table unit, with its bind.
`timescale 1ns / 1ps
module obst_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input obst_pkg::out_item_t out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // no input taken while results are pending
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open during emission");

  // final transfer ends the problem
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.last_result |=> !out_valid_o && !in_stall_o)
    else $error("block busy after final transfer");

  // subrange indices are ordered
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.range_start != 4'd0 &&
      (out_data_o.range_end >= out_data_o.range_start ||
       (out_data_o.range_start == 4'd1 && out_data_o.range_end == 4'd0)))
    else $error("bad subrange");

endmodule

bind optimal_bst_cost_table_unit obst_checker u_obst_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
